// File: rtl/plc_pkg.sv
package plc_pkg;

  localparam int CODE_LENGTH = 5;
  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [7:0] ACK_BYTE    = 8'h10;
  localparam logic [7:0] READY_BYTE  = 8'h11;
  localparam logic [7:0] OPEN_BYTE   = 8'h15;
  localparam logic [7:0] CHOICE_OPEN = 8'h2B;

  typedef enum logic [2:0] {
    MODE_SET     = 3'd1,
    MODE_CHOOSE  = 3'd2,
    MODE_OPEN    = 3'd3,
    MODE_CHANGE  = 3'd4,
    MODE_LOCKOUT = 3'd5,
    MODE_TIMED   = 3'd6
  } mode_t;

  localparam logic [1:0] MOTOR_STOP    = 2'd0;
  localparam logic [1:0] MOTOR_FORWARD = 2'd1;
  localparam logic [1:0] MOTOR_REVERSE = 2'd2;

  localparam logic [0:0] KIND_BYTE = 1'b0;
  localparam logic [0:0] KIND_TICK = 1'b1;

  localparam logic [1:0] TX_NONE = 2'd0;
  localparam logic [1:0] TX_PAIR = 2'd2;

  localparam logic [2:0] REG_STOP_TICK         = 3'd0;
  localparam logic [2:0] REG_REVERSE_TICK      = 3'd1;
  localparam logic [2:0] REG_CLOSE_DONE_TICK   = 3'd2;
  localparam logic [2:0] REG_LOCKOUT_DONE_TICK = 3'd3;
  localparam logic [2:0] REG_MAX_RETRIES       = 3'd4;

  localparam logic [7:0] STOP_TICK_RST         = 8'd15;
  localparam logic [7:0] REVERSE_TICK_RST      = 8'd18;
  localparam logic [7:0] CLOSE_DONE_TICK_RST   = 8'd33;
  localparam logic [7:0] LOCKOUT_DONE_TICK_RST = 8'd30;
  localparam logic [1:0] MAX_RETRIES_RST       = 2'd2;

endpackage

// File: rtl/plc_in_if.sv
interface plc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

// File: rtl/plc_out_if.sv
interface plc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] tx_count;
  logic [7:0] tx_first;
  logic [7:0] tx_second;
  logic [1:0] motor;
  logic       buzzer;
  logic [2:0] mode;

  modport source (output valid, output tx_count, output tx_first, output tx_second,
                  output motor, output buzzer, output mode, input ready);
  modport sink (input valid, input tx_count, input tx_first, input tx_second,
                input motor, input buzzer, input mode, output ready);
endinterface

// File: rtl/password_lock_controller_core.sv
// Password lock controller. Each item (a received link byte or one timer tick) is
// captured in an input register and processed once the output register is free or
// being read, which updates the lock state and loads exactly one result item into the
// output register. The block takes one item per cycle while the output side is ready.
// The input register accepts while it is empty, also while a result waits on the
// output, so one extra item can be absorbed during a stall. The tick thresholds and
// the retry limit are APB registers at byte addresses 0 to 16 and should only be
// written while no item is in flight.
module password_lock_controller_core
  import plc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  plc_in_if.sink             rx_item,
  plc_out_if.source          result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Configuration registers
  logic [7:0] stop_tick;
  logic [7:0] reverse_tick;
  logic [7:0] close_done_tick;
  logic [7:0] lockout_done_tick;
  logic [1:0] max_retries;

  // Input and output stages
  logic       in_valid;
  logic       in_kind;
  logic [7:0] in_byte;
  logic       out_valid;
  logic [1:0] out_tx_count;
  logic [7:0] out_tx_first;
  logic [7:0] out_tx_second;
  logic [1:0] out_motor;
  logic       out_buzzer;
  logic [2:0] out_mode;
  logic       advance;

  // Lock state
  mode_t            mode_reg, mode_reg_next;
  logic             await_ready, await_ready_next;
  logic             second_entry, second_entry_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [7:0]       first_entry [CODE_LENGTH];
  logic [7:0]       stored_password [CODE_LENGTH];
  logic             mismatch_seen, mismatch_seen_next;
  logic [1:0]       open_retries, open_retries_next;
  logic [1:0]       change_retries, change_retries_next;
  logic [7:0]       tick_count, tick_count_next;
  logic             timed_is_lockout, timed_is_lockout_next;
  logic [1:0]       motor_reg, motor_reg_next;
  logic             buzzer_reg, buzzer_reg_next;

  logic       first_we;
  logic       pw_copy;
  logic [1:0] tx_count;
  logic [7:0] tx_first;
  logic [7:0] tx_second;
  logic       cfg_write;

  // Scratch values of the item processing
  logic       byte_wrong;
  logic       entry_ok;
  logic       last_byte;
  logic [7:0] tick_inc;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (paddr[4:2])
      REG_STOP_TICK:         prdata = {24'd0, stop_tick};
      REG_REVERSE_TICK:      prdata = {24'd0, reverse_tick};
      REG_CLOSE_DONE_TICK:   prdata = {24'd0, close_done_tick};
      REG_LOCKOUT_DONE_TICK: prdata = {24'd0, lockout_done_tick};
      REG_MAX_RETRIES:       prdata = {30'd0, max_retries};
      default:               prdata = '0;
    endcase
  end

  assign advance       = in_valid && (!out_valid || result.ready);
  assign rx_item.ready = !in_valid || advance;

  assign result.valid     = out_valid;
  assign result.tx_count  = out_tx_count;
  assign result.tx_first  = out_tx_first;
  assign result.tx_second = out_tx_second;
  assign result.motor     = out_motor;
  assign result.buzzer    = out_buzzer;
  assign result.mode      = out_mode;

  always_comb begin
    mode_reg_next         = mode_reg;
    await_ready_next      = await_ready;
    second_entry_next     = second_entry;
    byte_index_next       = byte_index;
    mismatch_seen_next    = mismatch_seen;
    open_retries_next     = open_retries;
    change_retries_next   = change_retries;
    tick_count_next       = tick_count;
    timed_is_lockout_next = timed_is_lockout;
    motor_reg_next        = motor_reg;
    buzzer_reg_next       = buzzer_reg;
    first_we              = 1'b0;
    pw_copy               = 1'b0;
    tx_count              = TX_NONE;
    tx_first              = 8'd0;
    tx_second             = 8'd0;

    // During the first set-password entry nothing is compared.
    if (mode_reg == MODE_SET) begin
      byte_wrong = second_entry && (first_entry[byte_index] != in_byte);
    end else begin
      byte_wrong = (stored_password[byte_index] != in_byte);
    end
    entry_ok  = !(mismatch_seen || byte_wrong);
    last_byte = (byte_index == IDX_W'(CODE_LENGTH - 1));
    tick_inc  = tick_count + 8'd1;

    if (in_kind == KIND_TICK) begin
      if (mode_reg == MODE_TIMED) begin
        tick_count_next = tick_inc;
        if (timed_is_lockout) begin
          if (tick_inc == lockout_done_tick) begin
            tick_count_next = 8'd0;
            buzzer_reg_next = 1'b0;
            mode_reg_next   = MODE_CHOOSE;
          end
        end else if (tick_inc == stop_tick) begin
          motor_reg_next = MOTOR_STOP;
        end else if (tick_inc == reverse_tick) begin
          motor_reg_next = MOTOR_REVERSE;
        end else if (tick_inc == close_done_tick) begin
          motor_reg_next  = MOTOR_STOP;
          tick_count_next = 8'd0;
          mode_reg_next   = MODE_CHOOSE;
        end
      end
    end else if (mode_reg == MODE_TIMED) begin
      // Bytes are dropped while the door or lockout sequence runs.
    end else if (await_ready) begin
      if (in_byte == READY_BYTE) begin
        await_ready_next = 1'b0;
      end
    end else if (mode_reg == MODE_CHOOSE) begin
      mode_reg_next    = (in_byte == CHOICE_OPEN) ? MODE_OPEN : MODE_CHANGE;
      await_ready_next = 1'b1;
      tx_count         = TX_PAIR;
      tx_first         = ACK_BYTE;
      tx_second        = {5'd0, mode_reg_next};
    end else begin
      first_we           = (mode_reg == MODE_SET) && !second_entry;
      mismatch_seen_next = mismatch_seen || byte_wrong;
      byte_index_next    = byte_index + 1'b1;
      if (last_byte) begin
        byte_index_next    = '0;
        mismatch_seen_next = 1'b0;
        await_ready_next   = 1'b1;
        case (mode_reg)
          MODE_SET: begin
            second_entry_next = !second_entry;
            if (second_entry) begin
              if (entry_ok) begin
                pw_copy       = 1'b1;
                mode_reg_next = MODE_CHOOSE;
              end
              tx_count  = TX_PAIR;
              tx_first  = ACK_BYTE;
              tx_second = {5'd0, mode_reg_next};
            end
          end
          MODE_OPEN: begin
            tx_count = TX_PAIR;
            tx_first = ACK_BYTE;
            if (entry_ok) begin
              open_retries_next     = 2'd0;
              tx_second             = OPEN_BYTE;
              motor_reg_next        = MOTOR_FORWARD;
              timed_is_lockout_next = 1'b0;
              tick_count_next       = 8'd0;
              mode_reg_next         = MODE_TIMED;
            end else if (open_retries < max_retries) begin
              open_retries_next = open_retries + 2'd1;
              tx_second         = {5'd0, MODE_OPEN};
            end else begin
              open_retries_next     = 2'd0;
              tx_second             = {5'd0, MODE_LOCKOUT};
              buzzer_reg_next       = 1'b1;
              timed_is_lockout_next = 1'b1;
              tick_count_next       = 8'd0;
              mode_reg_next         = MODE_TIMED;
            end
          end
          default: begin
            tx_count = TX_PAIR;
            tx_first = ACK_BYTE;
            if (entry_ok) begin
              change_retries_next = 2'd0;
              mode_reg_next       = MODE_SET;
              tx_second           = {5'd0, MODE_SET};
            end else if (change_retries < max_retries) begin
              change_retries_next = change_retries + 2'd1;
              tx_second           = {5'd0, MODE_CHANGE};
            end else begin
              change_retries_next   = 2'd0;
              tx_second             = {5'd0, MODE_LOCKOUT};
              buzzer_reg_next       = 1'b1;
              timed_is_lockout_next = 1'b1;
              tick_count_next       = 8'd0;
              mode_reg_next         = MODE_TIMED;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_tick         <= STOP_TICK_RST;
      reverse_tick      <= REVERSE_TICK_RST;
      close_done_tick   <= CLOSE_DONE_TICK_RST;
      lockout_done_tick <= LOCKOUT_DONE_TICK_RST;
      max_retries       <= MAX_RETRIES_RST;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_STOP_TICK:         stop_tick         <= pwdata[7:0];
        REG_REVERSE_TICK:      reverse_tick      <= pwdata[7:0];
        REG_CLOSE_DONE_TICK:   close_done_tick   <= pwdata[7:0];
        REG_LOCKOUT_DONE_TICK: lockout_done_tick <= pwdata[7:0];
        REG_MAX_RETRIES:       max_retries       <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      out_valid        <= 1'b0;
      mode_reg         <= MODE_SET;
      await_ready      <= 1'b1;
      second_entry     <= 1'b0;
      byte_index       <= '0;
      mismatch_seen    <= 1'b0;
      open_retries     <= 2'd0;
      change_retries   <= 2'd0;
      tick_count       <= 8'd0;
      timed_is_lockout <= 1'b0;
      motor_reg        <= MOTOR_STOP;
      buzzer_reg       <= 1'b0;
    end else begin
      if (rx_item.ready) begin
        in_valid <= rx_item.valid;
      end
      if (advance) begin
        out_valid        <= 1'b1;
        mode_reg         <= mode_reg_next;
        await_ready      <= await_ready_next;
        second_entry     <= second_entry_next;
        byte_index       <= byte_index_next;
        mismatch_seen    <= mismatch_seen_next;
        open_retries     <= open_retries_next;
        change_retries   <= change_retries_next;
        tick_count       <= tick_count_next;
        timed_is_lockout <= timed_is_lockout_next;
        motor_reg        <= motor_reg_next;
        buzzer_reg       <= buzzer_reg_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_item.ready && rx_item.valid) begin
      in_kind <= rx_item.kind;
      in_byte <= rx_item.rx_byte;
    end
    if (advance) begin
      out_tx_count  <= tx_count;
      out_tx_first  <= tx_first;
      out_tx_second <= tx_second;
      out_motor     <= motor_reg_next;
      out_buzzer    <= buzzer_reg_next;
      out_mode      <= mode_reg_next;
      if (first_we) begin
        first_entry[byte_index] <= in_byte;
      end
      if (pw_copy) begin
        stored_password <= first_entry;
      end
    end
  end

`ifndef SYNTHESIS
  a_motor_only_on_door: assert property (@(posedge clk) disable iff (rst)
    (motor_reg != MOTOR_STOP) |-> (mode_reg == MODE_TIMED && !timed_is_lockout))
    else $error("motor driven outside the door sequence");

  a_buzzer_only_on_lockout: assert property (@(posedge clk) disable iff (rst)
    buzzer_reg |-> (mode_reg == MODE_TIMED && timed_is_lockout))
    else $error("buzzer on outside a lockout");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    byte_index <= IDX_W'(CODE_LENGTH - 1))
    else $error("entry byte index out of range");

  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed item did not produce a result");

  a_ack_with_pair: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_tx_count != TX_NONE) |-> (out_tx_first == ACK_BYTE))
    else $error("sent pair without acknowledge byte");
`endif

endmodule
